### hw/rtl/srsw_pkg.sv
package srsw_pkg;

    localparam int APB_AW = 4;

    localparam logic [1:0] REG_WINDOW   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_RETRY    = 2'd2;
    localparam logic [1:0] REG_SEGMENTS = 2'd3;

    localparam logic [6:0]  WINDOW_RST   = 7'd8;
    localparam logic [15:0] TIMEOUT_RST  = 16'd3000;
    localparam logic [7:0]  RETRY_RST    = 8'd5;
    localparam logic [31:0] SEGMENTS_RST = 32'd0;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam int STAMP_W = 32;
    localparam int ATT_W   = 8;
    localparam logic [ATT_W-1:0] ATT_MAX = 8'd255;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_IDLE  = 3'd0,
        ACT_NEW   = 3'd1,
        ACT_RETX  = 3'd2,
        ACT_ACK   = 3'd3,
        ACT_STRAY = 3'd4,
        ACT_DONE  = 3'd5
    } action_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] ack;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  win_limit;
        logic [15:0] timeout_ticks;
        logic [7:0]  retry_limit;
        logic [31:0] segment_count;
    } cfg_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] seq;
        logic [31:0] base_seq;
        logic [31:0] next_seq;
        logic [7:0]  attempts;
        logic        limit_reached;
        logic        done_res;
    } res_t;

endpackage

### hw/rtl/srsw_ram.sv
module srsw_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/srsw_front.sv
module srsw_front
    import srsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] ack_seq,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t       q_reg [2];
    cmd_t       in_cmd;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    always_comb
    begin
        in_cmd.ack = ack_seq;
        case (kind)
            KIND_SEND: in_cmd.op = OP_SEND;
            KIND_ACK:  in_cmd.op = OP_ACK;
            KIND_TICK: in_cmd.op = OP_TICK;
            default:   in_cmd.op = OP_NONE;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### hw/rtl/srsw_back.sv
module srsw_back
    import srsw_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    input  cfg_t cfg,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LANES  = (WINDOW_MAX < 8) ? WINDOW_MAX : 8;
    localparam int LANE_W = $clog2(LANES + 1);
    localparam int ENT_W  = STAMP_W + ATT_W;
    localparam logic [SLOT_W:0]   WMAX_S   = (SLOT_W + 1)'(WINDOW_MAX);
    localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WINDOW_MAX - 1);
    localparam logic [31:0]       WMAX32   = 32'(WINDOW_MAX);

    typedef enum logic [4:0] {
        ST_EXEC  = 5'b00001,
        ST_SLIDE = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_CAP   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [31:0]             base_reg, base_next;
    logic [31:0]             next_reg, next_next;
    logic [SLOT_W-1:0]       base_slot_reg, base_slot_next;
    logic [SLOT_W-1:0]       next_slot_reg, next_slot_next;
    logic [31:0]             tick_reg, tick_next;
    logic [WINDOW_MAX-1:0]   pending_reg, pending_next;
    logic                    finished_reg, finished_next;
    logic [STAMP_W-1:0]      stamp_reg, stamp_next;
    logic [ATT_W-1:0]        att_reg, att_next;
    action_t                 act_reg, act_next;
    logic [31:0]             seq_reg, seq_next;
    logic                    out_valid_reg, out_valid_next;
    res_t                    res_reg, res_next;

    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic [ENT_W-1:0]        ram_rdata;

    logic [31:0]             span;
    logic [31:0]             eff_win;
    logic [31:0]             ack_dist;
    logic [SLOT_W-1:0]       ack_slot;
    logic [SLOT_W-1:0]       next_slot_inc;
    logic [31:0]             tick_inc;
    logic [LANES-1:0]        lane_stop;
    logic [SLOT_W-1:0]       lane_slot [LANES];
    logic [LANE_W-1:0]       adv;
    logic                    slide_stop;
    logic [SLOT_W-1:0]       slide_slot;
    logic [31:0]             slide_base;
    logic                    fin_set;

    function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] s,
                                                   input logic [SLOT_W:0]   off);
        logic [SLOT_W:0] sum;
        sum = {1'b0, s} + off;
        if (sum >= WMAX_S)
        begin
            sum = sum - WMAX_S;
        end
        return sum[SLOT_W-1:0];
    endfunction

    srsw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_MAX)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (base_slot_reg),
        .rdata (ram_rdata)
    );

    assign span          = next_reg - base_reg;
    assign ack_dist      = cmd.ack - base_reg;
    assign ack_slot      = wrap_add(base_slot_reg, {1'b0, ack_dist[SLOT_W-1:0]});
    assign next_slot_inc = (next_slot_reg == SLOT_TOP) ? '0 : next_slot_reg + 1'b1;
    assign tick_inc      = tick_reg + 32'd1;

    always_comb
    begin
        eff_win = {25'd0, cfg.win_limit};
        if (eff_win == 32'd0)
        begin
            eff_win = 32'd1;
        end
        if (eff_win > WMAX32)
        begin
            eff_win = WMAX32;
        end
    end

    // The base slides over at most LANES acknowledged slots per cycle.
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lane_slot[k] = wrap_add(base_slot_reg, (SLOT_W + 1)'(k));
            lane_stop[k] = (32'(k) >= span) || pending_reg[lane_slot[k]];
        end
        adv        = LANE_W'(LANES);
        slide_stop = 1'b0;
        for (int k = LANES - 1; k >= 0; k--)
        begin
            if (lane_stop[k])
            begin
                adv        = LANE_W'(k);
                slide_stop = 1'b1;
            end
        end
        slide_slot = wrap_add(base_slot_reg, (SLOT_W + 1)'(adv));
        slide_base = base_reg + 32'(adv);
    end

    assign fin_set = !finished_reg && (next_reg >= cfg.segment_count) && (base_reg == next_reg);

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        next_next      = next_reg;
        base_slot_next = base_slot_reg;
        next_slot_next = next_slot_reg;
        tick_next      = tick_reg;
        pending_next   = pending_reg;
        finished_next  = finished_reg;
        stamp_next     = stamp_reg;
        att_next       = att_reg;
        act_next       = act_reg;
        seq_next       = seq_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !res_ready;
        cmd_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = next_slot_reg;
        ram_wdata      = {tick_reg, {ATT_W{1'b0}}};

        case (state_reg)
            ST_EXEC:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    state_next = ST_EMIT;
                    act_next   = ACT_IDLE;
                    seq_next   = '0;
                    if (finished_reg)
                    begin
                        act_next = ACT_DONE;
                    end
                    else
                    begin
                        case (cmd.op)
                            OP_SEND:
                            begin
                                if ((span < eff_win) && (next_reg < cfg.segment_count))
                                begin
                                    pending_next[next_slot_reg] = 1'b1;
                                    ram_we         = 1'b1;
                                    ram_waddr      = next_slot_reg;
                                    ram_wdata      = {tick_reg, {ATT_W{1'b0}}};
                                    if (base_reg == next_reg)
                                    begin
                                        stamp_next = tick_reg;
                                        att_next   = '0;
                                    end
                                    seq_next       = next_reg;
                                    next_next      = next_reg + 32'd1;
                                    next_slot_next = next_slot_inc;
                                    act_next       = ACT_NEW;
                                end
                            end
                            OP_ACK:
                            begin
                                seq_next = cmd.ack;
                                if ((ack_dist < span) && pending_reg[ack_slot])
                                begin
                                    pending_next[ack_slot] = 1'b0;
                                    act_next = ACT_ACK;
                                    if (ack_dist == 32'd0)
                                    begin
                                        state_next = ST_SLIDE;
                                    end
                                end
                                else
                                begin
                                    act_next = ACT_STRAY;
                                end
                            end
                            OP_TICK:
                            begin
                                tick_next = tick_inc;
                                if ((base_reg != next_reg) &&
                                    ((tick_inc - stamp_reg) >= {16'd0, cfg.timeout_ticks}))
                                begin
                                    att_next   = (att_reg == ATT_MAX) ? ATT_MAX : att_reg + 1'b1;
                                    stamp_next = tick_inc;
                                    ram_we     = 1'b1;
                                    ram_waddr  = base_slot_reg;
                                    ram_wdata  = {tick_inc, att_next};
                                    seq_next   = base_reg;
                                    act_next   = ACT_RETX;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_SLIDE:
            begin
                base_next      = slide_base;
                base_slot_next = slide_slot;
                if (slide_stop)
                begin
                    state_next = (slide_base != next_reg) ? ST_LOAD : ST_EMIT;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                stamp_next = ram_rdata[ENT_W-1:ATT_W];
                att_next   = ram_rdata[ATT_W-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next         = 1'b1;
                    finished_next          = finished_reg || fin_set;
                    res_next.action        = (fin_set && act_reg == ACT_IDLE) ? ACT_DONE : act_reg;
                    res_next.seq           = seq_reg;
                    res_next.base_seq      = base_reg;
                    res_next.next_seq      = next_reg;
                    res_next.attempts      = (base_reg != next_reg) ? att_reg : '0;
                    res_next.limit_reached = (base_reg != next_reg) &&
                                             (att_reg >= cfg.retry_limit);
                    res_next.done_res      = finished_reg || fin_set;
                    state_next             = ST_EXEC;
                end
            end
            default:
            begin
                state_next = ST_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EXEC;
            base_reg      <= '0;
            next_reg      <= '0;
            base_slot_reg <= '0;
            next_slot_reg <= '0;
            tick_reg      <= '0;
            pending_reg   <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            base_slot_reg <= base_slot_next;
            next_slot_reg <= next_slot_next;
            tick_reg      <= tick_next;
            pending_reg   <= pending_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        att_reg   <= att_next;
        act_reg   <= act_next;
        seq_reg   <= seq_next;
        res_reg   <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

### hw/rtl/selective_repeat_sender_window.sv
// Sender side of a selective-repeat window. Each item is a send request, an
// acknowledgement or a tick, and each gives exactly one result item. Items
// enter a two-entry queue and are carried out one at a time by the back end.
// A send, a tick, a stray acknowledgement or an acknowledgement of a number
// above the base is carried out in an execute step that updates the window
// and the slot RAM, followed by an emit step that loads the result register.
// An acknowledgement of the base segment also slides the base up to 8
// acknowledged slots per cycle and then, unless the window is left empty,
// reads the new base segment's stamp and attempt count from the slot RAM in
// a load step and a capture step. A stalled result holds back the next one.
// Once every segment is sent and acknowledged the block reports complete and
// holds its state until reset.
module selective_repeat_sender_window
    import srsw_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  logic [31:0]       ack_seq,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        action,
    output logic [31:0]       seq,
    output logic [31:0]       base_seq,
    output logic [31:0]       next_seq,
    output logic [7:0]        attempts,
    output logic              limit_reached,
    output logic              done_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_we;
    logic [1:0] reg_idx;
    logic       cmd_valid;
    logic       cmd_ready;
    cmd_t       cmd;
    res_t       res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx)
                REG_WINDOW:   cfg_next.win_limit     = pwdata[6:0];
                REG_TIMEOUT:  cfg_next.timeout_ticks = pwdata[15:0];
                REG_RETRY:    cfg_next.retry_limit   = pwdata[7:0];
                REG_SEGMENTS: cfg_next.segment_count = pwdata;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WINDOW:   prdata = {25'd0, cfg_reg.win_limit};
            REG_TIMEOUT:  prdata = {16'd0, cfg_reg.timeout_ticks};
            REG_RETRY:    prdata = {24'd0, cfg_reg.retry_limit};
            REG_SEGMENTS: prdata = cfg_reg.segment_count;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_limit     <= WINDOW_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.retry_limit   <= RETRY_RST;
            cfg_reg.segment_count <= SEGMENTS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    srsw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .ack_seq   (ack_seq),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    srsw_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign action        = res.action;
    assign seq           = res.seq;
    assign base_seq      = res.base_seq;
    assign next_seq      = res.next_seq;
    assign attempts      = res.attempts;
    assign limit_reached = res.limit_reached;
    assign done_res      = res.done_res;

endmodule

### hw/rtl/srsw_checker.sv
module srsw_checker
    import srsw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  action,
    input logic [31:0] seq,
    input logic [31:0] base_seq,
    input logic [31:0] next_seq,
    input logic [7:0]  attempts,
    input logic        limit_reached
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(seq))
        else $error("Result item changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_NEW) |-> (seq + 32'd1 == next_seq))
        else $error("New send does not match the next sequence number.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_RETX) |-> (seq == base_seq) && (base_seq != next_seq))
        else $error("Retransmission is not of a pending base segment.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (base_seq == next_seq) |-> (attempts == 8'd0) && !limit_reached)
        else $error("Attempt count reported with an empty window.");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (.*);
